[rtl/core/aae_pkg.sv]
package aae_pkg;

   localparam int ALPHA_W    = 9;
   localparam int SYMBOL_W   = 8;
   localparam int FOLLOW_W   = 16;
   localparam int RESULT_CAP = 24;
   localparam int CNT_W      = $clog2(RESULT_CAP + 1);

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   typedef struct packed {
      logic                lead_bit;
      logic [FOLLOW_W-1:0] follow_count;
      logic                pending_overflow;
      logic                last;
   } rsp_word_type;

endpackage

[rtl/core/aae_if.sv]
interface aae_req_if import aae_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                command;
   logic [SYMBOL_W-1:0] symbol;

   modport source (output valid, command, symbol, input ready);
   modport sink   (input valid, command, symbol, output ready);
endinterface

interface aae_rsp_if import aae_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                lead_bit;
   logic [FOLLOW_W-1:0] follow_count;
   logic                pending_overflow;
   logic                last;

   modport source (output valid, lead_bit, follow_count, pending_overflow, last, input ready);
   modport sink   (input valid, lead_bit, follow_count, pending_overflow, last, output ready);
endinterface

[rtl/core/adaptive_arithmetic_encoder.sv]
// Adaptive multi-symbol arithmetic encoder. An encode word reads the total and the two
// bounds of its symbol from the count memory, divides the range by the total in a
// one-bit-per-cycle restoring divider, forms the new low and range from two products,
// renormalizes one bit per cycle while rsp_if is not stalled, flushes its last result
// and walks counts 1..K (K the effective alphabet size) through the memory port one
// entry per cycle. A finish word shifts out CODE_BITS bits of low and then runs a pass
// over all MAX_SYMBOLS+1 entries that rewrites the count memory; the same pass runs
// after reset and after each csr write, and req_if is not ready during it. Symbols not
// below the effective alphabet size are dropped without a result.
module adaptive_arithmetic_encoder import aae_pkg::*; #(
   parameter int CODE_BITS     = 24,
   parameter int MAX_SYMBOLS   = 256,
   parameter int PENDING_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   aae_req_if.sink            req_if,
   aae_rsp_if.source          rsp_if,
   input  logic               csr_we,
   input  logic [ALPHA_W-1:0] csr_wdata
);

   localparam int LW  = CODE_BITS + 1;
   localparam int CW  = (CODE_BITS - 1 > 10) ? CODE_BITS - 1 : 10;
   localparam int AW  = $clog2(MAX_SYMBOLS + 1);
   localparam int PW  = PENDING_WIDTH;
   localparam int DW  = $clog2(LW + 1);
   localparam int PRW = LW + CW;
   localparam logic [LW-1:0] Q2 = LW'(1) << (CODE_BITS - 1);
   localparam logic [LW-1:0] Q1 = LW'(1) << (CODE_BITS - 2);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_RK, S_RL, S_RH, S_DSET, S_DIV, S_MUL1, S_MUL2, S_MUL3,
      S_NORM, S_FIN, S_FLUSH, S_ADAPT0, S_ADAPT
   } state_type;

   logic [CW-1:0] mem [MAX_SYMBOLS+1];
   logic [CW-1:0] rdata_ff;
   logic [AW-1:0] mem_raddr;
   logic          mem_we;
   logic [CW-1:0] mem_wdata;

   state_type           state_ff, state_in;
   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic                cmd_ff, cmd_in;
   logic [LW-1:0]       low_ff, low_in;
   logic [LW-1:0]       range_ff, range_in;
   logic [PW-1:0]       pending_ff, pending_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                held_v_ff, held_v_in;
   rsp_word_type        held_ff, held_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_data_ff, rsp_data_in;
   logic [DW-1:0]       dcnt_ff, dcnt_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [LW-1:0]       dq_ff, dq_in;
   logic [CW-1:0]       total_ff, total_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic                halve_ff, halve_in;
   logic [PRW-1:0]      prod_ff, prod_in;
   logic [CW-1:0]       prev_old_ff, prev_old_in;
   logic [CW-1:0]       newprev_ff, newprev_in;

   logic [AW-1:0]  k;
   logic           out_free;
   logic           emit_ok;
   logic           do_emit;
   logic           emit_bit;
   logic [31:0]    pend32;
   logic [CW:0]    trial;
   logic [CW-1:0]  diff;
   logic [CW:0]    half_w;
   logic [CW-1:0]  nh;
   logic [LW-1:0]  step;
   logic [LW-1:0]  low_sub;
   logic [LW:0]    low_top;

   always_comb begin
      if (alpha_ff == '0) begin
         k = AW'(1);
      end else if (32'(alpha_ff) > MAX_SYMBOLS) begin
         k = AW'(MAX_SYMBOLS);
      end else begin
         k = AW'(alpha_ff);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign emit_ok  = !held_v_ff || out_free || (32'(cnt_ff) == RESULT_CAP);
   assign pend32   = 32'(pending_ff);
   assign trial    = {rem_ff, dq_ff[LW-1]} - {1'b0, total_ff};
   assign diff     = rdata_ff - prev_old_ff;
   assign half_w   = ({1'b0, diff} + (CW+1)'(1)) >> 1;
   assign nh       = halve_ff ? newprev_ff + half_w[CW-1:0] : rdata_ff;
   assign step     = (dq_ff == '0) ? LW'(1) : dq_ff;
   assign low_top  = {1'b0, low_ff} + {1'b0, range_ff};

   always_comb begin
      state_in     = state_ff;
      alpha_in     = alpha_ff;
      idx_in       = idx_ff;
      sym_in       = sym_ff;
      cmd_in       = cmd_ff;
      low_in       = low_ff;
      range_in     = range_ff;
      pending_in   = pending_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      held_v_in    = held_v_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      dcnt_in      = dcnt_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      total_in     = total_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      halve_in     = halve_ff;
      prod_in      = prod_ff;
      prev_old_in  = prev_old_ff;
      newprev_in   = newprev_ff;
      mem_raddr    = '0;
      mem_we       = 1'b0;
      mem_wdata    = nh + CW'(32'(idx_ff) > 32'(sym_ff));
      do_emit      = 1'b0;
      emit_bit     = 1'b0;
      low_sub      = low_ff - Q1;

      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = CW'(idx_ff);
            if (32'(idx_ff) == MAX_SYMBOLS) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               cnt_in  = '0;
               dcnt_in = '0;
               sym_in  = req_if.symbol;
               cmd_in  = req_if.command;
               if (req_if.command == CMD_FINISH) begin
                  state_in = S_FIN;
               end else if (32'(req_if.symbol) < 32'(k)) begin
                  state_in = S_RK;
               end
            end
         end
         S_RK: begin
            mem_raddr = k;
            state_in  = S_RL;
         end
         S_RL: begin
            mem_raddr = AW'(sym_ff);
            total_in  = rdata_ff;
            state_in  = S_RH;
         end
         S_RH: begin
            mem_raddr = AW'(sym_ff) + AW'(1);
            lo_in     = rdata_ff;
            state_in  = S_DSET;
         end
         S_DSET: begin
            hi_in    = rdata_ff;
            rem_in   = '0;
            dq_in    = range_ff;
            dcnt_in  = '0;
            halve_in = 64'(total_ff) >= 64'(Q1);
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (!trial[CW]) begin
               rem_in = trial[CW-1:0];
            end else begin
               rem_in = {rem_ff[CW-2:0], dq_ff[LW-1]};
            end
            dq_in   = {dq_ff[LW-2:0], !trial[CW]};
            dcnt_in = dcnt_ff + DW'(1);
            if (32'(dcnt_ff) == LW - 1) begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            dq_in   = step;
            prod_in = step * lo_ff;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            low_in   = low_ff + prod_ff[LW-1:0];
            prod_in  = dq_ff * (hi_ff - lo_ff);
            state_in = S_MUL3;
         end
         S_MUL3: begin
            range_in = (prod_ff == '0) ? LW'(1) : prod_ff[LW-1:0];
            state_in = S_NORM;
         end
         S_NORM: begin
            if (range_ff > Q1) begin
               state_in = S_FLUSH;
            end else if (low_ff >= Q2) begin
               if (emit_ok) begin
                  do_emit    = 1'b1;
                  emit_bit   = 1'b1;
                  pending_in = '0;
                  low_sub    = low_ff - Q2;
                  low_in     = {low_sub[LW-2:0], 1'b0};
                  range_in   = {range_ff[LW-2:0], 1'b0};
               end
            end else if (low_top <= {1'b0, Q2}) begin
               if (emit_ok) begin
                  do_emit    = 1'b1;
                  pending_in = '0;
                  low_in     = {low_ff[LW-2:0], 1'b0};
                  range_in   = {range_ff[LW-2:0], 1'b0};
               end
            end else begin
               // straddle: defer the bit
               if (pending_ff == '1) begin
                  ovf_in = 1'b1;
               end else begin
                  pending_in = pending_ff + PW'(1);
               end
               low_in   = {low_sub[LW-2:0], 1'b0};
               range_in = {range_ff[LW-2:0], 1'b0};
            end
         end
         S_FIN: begin
            if (emit_ok) begin
               do_emit    = 1'b1;
               emit_bit   = low_ff[CODE_BITS-1];
               pending_in = '0;
               low_in     = {low_ff[LW-2:0], 1'b0};
               dcnt_in    = dcnt_ff + DW'(1);
               if (32'(dcnt_ff) == CODE_BITS - 1) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (!held_v_ff || out_free) begin
               if (held_v_ff) begin
                  rsp_valid_in     = 1'b1;
                  rsp_data_in      = held_ff;
                  rsp_data_in.last = 1'b1;
                  held_v_in        = 1'b0;
               end
               if (cmd_ff == CMD_FINISH) begin
                  low_in     = '0;
                  range_in   = Q2;
                  pending_in = '0;
                  ovf_in     = 1'b0;
                  idx_in     = '0;
                  state_in   = S_INIT;
               end else begin
                  state_in = S_ADAPT0;
               end
            end
         end
         S_ADAPT0: begin
            mem_raddr   = AW'(1);
            idx_in      = AW'(1);
            prev_old_in = '0;
            newprev_in  = '0;
            state_in    = S_ADAPT;
         end
         S_ADAPT: begin
            // write entry idx while entry idx+1 is read
            mem_raddr   = idx_ff + AW'(1);
            mem_we      = 1'b1;
            prev_old_in = rdata_ff;
            newprev_in  = nh;
            if (idx_ff == k) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_INIT;
            idx_in   = '0;
         end
      endcase

      if (do_emit && (32'(cnt_ff) != RESULT_CAP)) begin
         if (held_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = held_ff;
         end
         held_v_in                = 1'b1;
         held_in.lead_bit         = emit_bit;
         held_in.follow_count     = (pend32 > 32'hFFFF) ? '1 : pend32[FOLLOW_W-1:0];
         held_in.pending_overflow = ovf_ff;
         held_in.last             = 1'b0;
         cnt_in                   = cnt_ff + CNT_W'(1);
      end

      if (csr_we) begin
         alpha_in = csr_wdata;
         idx_in   = '0;
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         alpha_ff     <= ALPHA_W'(256);
         idx_ff       <= '0;
         low_ff       <= '0;
         range_ff     <= Q2;
         pending_ff   <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         held_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= CMD_ENCODE;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         idx_ff       <= idx_in;
         low_ff       <= low_in;
         range_ff     <= range_in;
         pending_ff   <= pending_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         held_v_ff    <= held_v_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
         dcnt_ff      <= dcnt_in;
      end
      sym_ff      <= sym_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
      rem_ff      <= rem_in;
      dq_ff       <= dq_in;
      total_ff    <= total_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      halve_ff    <= halve_in;
      prod_ff     <= prod_in;
      prev_old_ff <= prev_old_in;
      newprev_ff  <= newprev_in;
   end

   assign req_if.ready            = (state_ff == S_IDLE);
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.lead_bit         = rsp_data_ff.lead_bit;
   assign rsp_if.follow_count     = rsp_data_ff.follow_count;
   assign rsp_if.pending_overflow = rsp_data_ff.pending_overflow;
   assign rsp_if.last             = rsp_data_ff.last;

   a_no_held_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !held_v_ff)
      else $error("result word left behind after item completed");

   a_cnt_capped: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= RESULT_CAP)
      else $error("result count above cap");

   a_range_normalized: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADAPT0) |-> (range_ff > Q1))
      else $error("range not renormalized before model update");

   a_no_emit_lost: assert property (@(posedge clock) disable iff (reset)
      (held_v_ff && rsp_valid_ff && !rsp_if.ready) |=> $stable(held_ff))
      else $error("held word overwritten while output stalled");

endmodule
